// ----- hdl/cbld_pkg.sv -----
// ----------------------------------------------------------------------------
// cbld_pkg
// Shared constants, types and helpers for the charlieplexed BCM LED driver.
// ----------------------------------------------------------------------------
package cbld_pkg;

  localparam int LINES      = 5;
  localparam int MOD_CYCLES = 4;
  localparam int LED_COUNT  = LINES * (LINES - 1);
  localparam int LINE_W     = $clog2(LINES);
  localparam int CYC_W      = $clog2(MOD_CYCLES);
  localparam int WORD_W     = MOD_CYCLES * LINES;
  localparam int POS_W      = 5;
  localparam int BRT_W      = 8;
  localparam int TICK_W     = 8;
  localparam int NUM_REGS   = 4;
  localparam int REG_IDX_W  = 2;
  localparam int PADDR_W    = REG_IDX_W + 2;

  typedef logic [LINES-1:0]  line_mask_t;
  typedef logic [WORD_W-1:0] dir_word_t;
  typedef logic [LINE_W-1:0] line_idx_t;

  // Request bundle to the direction memory: one read and one write port.
  typedef struct packed {
    logic      rd_en;
    line_idx_t rd_addr;
    logic      wr_en;
    line_idx_t wr_addr;
    dir_word_t wr_data;
  } mem_req_t;

  // Phase length registers after reset, cycles zero to three.
  function automatic logic [TICK_W-1:0] tick_reset(input logic [REG_IDX_W-1:0] idx);
    logic [TICK_W-1:0] val;
    case (idx)
      2'd0:    val = 8'd1;
      2'd1:    val = 8'd2;
      2'd2:    val = 8'd8;
      default: val = 8'd16;
    endcase
    return val;
  endfunction

  // Reset content of one column word: only the column's own line in every cycle.
  function automatic dir_word_t reset_word(input line_idx_t col);
    dir_word_t w;
    w = '0;
    for (int c = 0; c < MOD_CYCLES; c++) begin
      w[c*LINES + int'(col)] = 1'b1;
    end
    return w;
  endfunction

  // Column of an LED: position / (LINES-1) by compare against constant bounds.
  function automatic line_idx_t col_of(input logic [POS_W-1:0] pos);
    line_idx_t col;
    col = '0;
    for (int c = 1; c < LINES; c++) begin
      if (pos >= POS_W'(c * (LINES - 1))) col = LINE_W'(c);
    end
    return col;
  endfunction

  // Row line of an LED: the k-th line other than its column.
  function automatic line_idx_t row_of(input logic [POS_W-1:0] pos, input line_idx_t col);
    logic [POS_W-1:0] k;
    line_idx_t        row;
    k   = pos - POS_W'(col * (LINES - 1));
    row = (LINE_W'(k) < col) ? LINE_W'(k) : LINE_W'(k) + LINE_W'(1);
    return row;
  endfunction

endpackage

// ----- hdl/cbld_dir_mem.sv -----
// ----------------------------------------------------------------------------
// cbld_dir_mem
// Direction table, one word per column holding every cycle's mask, with
// per-row valid bits standing in for the reset content.
// ----------------------------------------------------------------------------
module cbld_dir_mem (
  input  logic               clk,
  input  logic               rst_n,
  input  cbld_pkg::mem_req_t req,
  output cbld_pkg::dir_word_t rd_word
);

  cbld_pkg::dir_word_t  mem_r [cbld_pkg::LINES];
  logic [cbld_pkg::LINES-1:0] valid_r;
  cbld_pkg::dir_word_t  rd_data_r;
  cbld_pkg::line_idx_t  rd_addr_r;
  logic                 rd_hit_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem_r[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem_r[req.rd_addr];
      rd_addr_r <= req.rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_hit_r <= 1'b0;
    end else begin
      if (req.wr_en) valid_r[req.wr_addr] <= 1'b1;
      if (req.rd_en) rd_hit_r <= valid_r[req.rd_addr];
    end
  end

  // Untouched rows read as their reset pattern.
  assign rd_word = rd_hit_r ? rd_data_r : cbld_pkg::reset_word(rd_addr_r);

endmodule

// ----- hdl/charlieplex_bcm_led_driver_core.sv -----
// ----------------------------------------------------------------------------
// charlieplex_bcm_led_driver_core
// Each item is taken in ST_IDLE, which issues any table read, and finishes in
// ST_RD, which merges into the table or latches the read word onto the pins. No
// new item is taken before the last one finishes, and a held result stalls
// ST_RD until it leaves. Synchronous active-low reset puts the pins at line A
// output, phase and cycle zero, default phase lengths.
// ----------------------------------------------------------------------------
module charlieplex_bcm_led_driver_core (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [4:0] led_position, [12:5] brightness, rest zero
  input  logic        in_tuser,   // [0] func (0 tick, 1 set brightness)
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [4:0] line_dir, [9:5] line_high, rest zero
  output logic        out_tuser,  // [0] phase_advanced
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam logic ST_IDLE = 1'b0;  // wait for an input transfer
  localparam logic ST_RD   = 1'b1;  // table word arrives, finish the item

  // --------------------------------------------------------------------------
  // Phase length registers
  // --------------------------------------------------------------------------
  logic [cbld_pkg::TICK_W-1:0] ticks_r [cbld_pkg::NUM_REGS];
  logic [cbld_pkg::REG_IDX_W-1:0] cfg_idx;
  logic cfg_wr;

  assign cfg_idx    = cfg_paddr[cbld_pkg::PADDR_W-1:2];
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = {{(32-cbld_pkg::TICK_W){1'b0}}, ticks_r[cfg_idx]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < cbld_pkg::NUM_REGS; i++) begin
        ticks_r[i] <= cbld_pkg::tick_reset(cbld_pkg::REG_IDX_W'(i));
      end
    end else if (cfg_wr) begin
      ticks_r[cfg_idx] <= cfg_pwdata[cbld_pkg::TICK_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Control and sequencing state
  // --------------------------------------------------------------------------
  logic                          state_r, state_nxt;
  cbld_pkg::line_idx_t           phase_r, phase_nxt;
  logic [cbld_pkg::CYC_W-1:0]    cycle_r, cycle_nxt;
  logic [cbld_pkg::TICK_W-1:0]   tick_r,  tick_nxt;
  cbld_pkg::line_mask_t          drive_dir_r, drive_dir_nxt;
  cbld_pkg::line_mask_t          drive_high_r, drive_high_nxt;

  // item held across the memory read
  logic                          is_set_r;
  logic                          adv_r;
  logic                          in_range_r;
  cbld_pkg::line_idx_t           col_r;
  cbld_pkg::line_idx_t           row_r;
  logic [cbld_pkg::MOD_CYCLES-1:0] nib_r;

  logic                          out_valid_r;
  cbld_pkg::line_mask_t          out_dir_r, out_high_r;
  logic                          out_adv_r;

  logic                          in_xfer;
  logic                          out_free;
  logic                          finish;
  logic                          in_func;
  logic [cbld_pkg::POS_W-1:0]    in_pos;
  logic [cbld_pkg::BRT_W-1:0]    in_brt;
  cbld_pkg::line_idx_t           in_col;
  logic [cbld_pkg::TICK_W-1:0]   tick_inc;
  logic                          expire;
  cbld_pkg::line_idx_t           phase_adv;
  logic [cbld_pkg::CYC_W-1:0]    cycle_adv;
  cbld_pkg::dir_word_t           rd_word;
  cbld_pkg::dir_word_t           merged;
  cbld_pkg::mem_req_t            mem_req;

  assign in_func = in_tuser;
  assign in_pos  = in_tdata[cbld_pkg::POS_W-1:0];
  assign in_brt  = in_tdata[cbld_pkg::POS_W +: cbld_pkg::BRT_W];
  assign in_col  = cbld_pkg::col_of(in_pos);

  // Take a new item whenever idle; the output register decouples the sink.
  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid & in_tready;
  assign out_free  = ~out_valid_r | out_tready;
  assign finish    = (state_r == ST_RD) & out_free;

  // Tick counting: expiry compares the incremented count with the cycle's length.
  assign tick_inc = tick_r + cbld_pkg::TICK_W'(1);
  assign expire   = (tick_inc >= ticks_r[cycle_r[cbld_pkg::REG_IDX_W-1:0]]);

  always_comb begin
    if (phase_r == cbld_pkg::LINE_W'(cbld_pkg::LINES - 1)) begin
      phase_adv = '0;
      cycle_adv = (cycle_r == cbld_pkg::CYC_W'(cbld_pkg::MOD_CYCLES - 1)) ?
                  '0 : cycle_r + cbld_pkg::CYC_W'(1);
    end else begin
      phase_adv = phase_r + cbld_pkg::LINE_W'(1);
      cycle_adv = cycle_r;
    end
  end

  // Merge the brightness nibble into the column word at the row line.
  always_comb begin
    merged = rd_word;
    for (int c = 0; c < cbld_pkg::MOD_CYCLES; c++) begin
      merged[c*cbld_pkg::LINES + int'(row_r)] = nib_r[c];
    end
  end

  // Read on a set or expiring tick; write the merged word back for in-range sets.
  always_comb begin
    mem_req.rd_en   = in_xfer & (in_func | expire);
    mem_req.rd_addr = in_func ? in_col : phase_adv;
    mem_req.wr_en   = finish & is_set_r & in_range_r;
    mem_req.wr_addr = col_r;
    mem_req.wr_data = merged;
  end

  cbld_dir_mem u_dir_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mem_req),
    .rd_word (rd_word)
  );

  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    cycle_nxt      = cycle_r;
    tick_nxt       = tick_r;
    drive_dir_nxt  = drive_dir_r;
    drive_high_nxt = drive_high_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = ST_RD;
          if (!in_func) begin
            if (expire) begin
              phase_nxt = phase_adv;
              cycle_nxt = cycle_adv;
              tick_nxt  = '0;
            end else begin
              tick_nxt  = tick_inc;
            end
          end
        end
      end
      ST_RD: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
          // latch the new phase's mask onto the pins, column line high
          if (!is_set_r && adv_r) begin
            drive_dir_nxt  = rd_word[int'(cycle_r)*cbld_pkg::LINES +: cbld_pkg::LINES];
            drive_high_nxt = cbld_pkg::line_mask_t'(1) << phase_r;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      phase_r      <= '0;
      cycle_r      <= '0;
      tick_r       <= '0;
      drive_dir_r  <= cbld_pkg::line_mask_t'(1);
      drive_high_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      cycle_r      <= cycle_nxt;
      tick_r       <= tick_nxt;
      drive_dir_r  <= drive_dir_nxt;
      drive_high_r <= drive_high_nxt;
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold the item's decoded fields while the table word comes back.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      is_set_r   <= in_func;
      adv_r      <= expire;
      in_range_r <= (in_pos < cbld_pkg::POS_W'(cbld_pkg::LED_COUNT));
      col_r      <= in_col;
      row_r      <= cbld_pkg::row_of(in_pos, in_col);
      nib_r      <= in_brt[cbld_pkg::BRT_W-1 -: cbld_pkg::MOD_CYCLES];
    end
    if (finish) begin
      out_dir_r  <= drive_dir_nxt;
      out_high_r <= drive_high_nxt;
      out_adv_r  <= ~is_set_r & adv_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_adv_r;
  assign out_tdata  = {{(16 - 2*cbld_pkg::LINES){1'b0}}, out_high_r, out_dir_r};

endmodule

// ----- tb/sv/tb_charlieplex_bcm_led_driver_core.sv -----
// ----------------------------------------------------------------------------
// tb_charlieplex_bcm_led_driver_core
// Self-checking bench for the charlieplexed BCM LED driver core. A short table
// of hand-picked items runs first: reset pins, out-of-range LED positions and
// brightness extremes; a lowered phase length and zero-length phases follow. Random
// phases follow under different phase-length settings. A per-item
// predictor tracks the direction table, phase, cycle and tick count, and every
// result transfer is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_charlieplex_bcm_led_driver_core;

  // Item kinds carried on in_tuser.
  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_SET  = 1'b1;

  // Phase length registers, by index.
  localparam int REG_TICKS_C0 = 0;
  localparam int REG_TICKS_C1 = 1;
  localparam int REG_TICKS_C2 = 2;
  localparam int REG_TICKS_C3 = 3;

  localparam int DRAIN_CYCLES   = 6;       // extra wait after the results drain
  localparam int CYCLE_LIMIT    = 400000;
  localparam int RAND_PHASES    = 10;
  localparam int ITEMS_PER_PHASE = 115;
  localparam int N_DIRECTED     = 25;

  // Pin state of one result: line_dir, line_high, phase_advanced.
  typedef struct packed {
    cbld_pkg::line_mask_t dir;
    cbld_pkg::line_mask_t high;
    logic                 adv;
  } pins_t;

  // One row of the directed table; pinned rows carry a hand-written result.
  typedef struct packed {
    logic                       is_set;
    logic [cbld_pkg::POS_W-1:0] pos;
    logic [cbld_pkg::BRT_W-1:0] brt;
    logic                       pinned;
    pins_t                      pins;
  } stim_row_t;

  localparam pins_t NO_PIN = '0;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tuser;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Side-band travelling with each input transfer: a hand-written result.
  logic  pin_en = 1'b0;
  pins_t pin_val = '0;

  charlieplex_bcm_led_driver_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor state: a private copy of the driver's table, counters and pins.
  // --------------------------------------------------------------------------
  cbld_pkg::line_mask_t          dir_tab [cbld_pkg::WORD_W];
  logic [cbld_pkg::TICK_W-1:0]   tick_len [cbld_pkg::NUM_REGS];
  logic [cbld_pkg::LINE_W-1:0]   phase_idx;
  logic [cbld_pkg::CYC_W-1:0]    cyc_idx;
  logic [cbld_pkg::TICK_W-1:0]   tick_cnt;
  cbld_pkg::line_mask_t          drv_dir;
  cbld_pkg::line_mask_t          drv_high;

  pins_t pending_pins [$];
  pins_t next_pins;
  pins_t head_pins;
  int    mismatches = 0;
  int    cycle_cnt = 0;

  function automatic void reset_pins_model();
    tick_len[REG_TICKS_C0] = 8'd1;
    tick_len[REG_TICKS_C1] = 8'd2;
    tick_len[REG_TICKS_C2] = 8'd8;
    tick_len[REG_TICKS_C3] = 8'd16;
    for (int i = 0; i < cbld_pkg::WORD_W; i++)
      dir_tab[i] = cbld_pkg::line_mask_t'(1) << (i % cbld_pkg::LINES);
    phase_idx = '0;
    cyc_idx   = '0;
    tick_cnt  = '0;
    drv_dir   = cbld_pkg::line_mask_t'(1);
    drv_high  = '0;
  endfunction

  // Apply one item to the predictor and return the pins it leaves behind.
  function automatic pins_t predict_pins(input logic is_set,
                                         input logic [cbld_pkg::POS_W-1:0] pos,
                                         input logic [cbld_pkg::BRT_W-1:0] brt);
    pins_t                      r;
    int                         col;
    int                         k;
    int                         row;
    logic [cbld_pkg::BRT_W-1:0] nib;
    r.adv = 1'b0;
    if (is_set == FUNC_SET) begin
      // Positions past the last LED leave the table alone.
      if (int'(pos) < cbld_pkg::LED_COUNT) begin
        col = int'(pos) / (cbld_pkg::LINES - 1);
        k   = int'(pos) % (cbld_pkg::LINES - 1);
        row = (k < col) ? k : k + 1;
        nib = brt >> (cbld_pkg::BRT_W - cbld_pkg::MOD_CYCLES);
        for (int c = 0; c < cbld_pkg::MOD_CYCLES; c++)
          dir_tab[c*cbld_pkg::LINES + col][row] = nib[c];
      end
    end else begin
      tick_cnt = tick_cnt + 1'b1;
      if (tick_cnt >= tick_len[cyc_idx]) begin
        if (int'(phase_idx) == cbld_pkg::LINES - 1) begin
          phase_idx = '0;
          cyc_idx   = (int'(cyc_idx) == cbld_pkg::MOD_CYCLES - 1) ? '0 : cyc_idx + 1'b1;
        end else begin
          phase_idx = phase_idx + 1'b1;
        end
        drv_dir  = dir_tab[int'(cyc_idx)*cbld_pkg::LINES + int'(phase_idx)];
        drv_high = cbld_pkg::line_mask_t'(1) << phase_idx;
        tick_cnt = '0;
        r.adv    = 1'b1;
      end
    end
    r.dir  = drv_dir;
    r.high = drv_high;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: check result transfers first, then predict accepted items, then
  // pick up register writes. Everything samples pre-edge values.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (pending_pins.size() == 0) begin
          $error("result transfer with nothing pending: tdata=%h tuser=%b",
                 out_tdata, out_tuser);
          mismatches++;
        end else begin
          head_pins = pending_pins.pop_front();
          if (out_tdata[4:0] !== head_pins.dir) begin
            $error("line_dir: expected %b, got %b", head_pins.dir, out_tdata[4:0]);
            mismatches++;
          end
          if (out_tdata[9:5] !== head_pins.high) begin
            $error("line_high: expected %b, got %b", head_pins.high, out_tdata[9:5]);
            mismatches++;
          end
          if (out_tuser !== head_pins.adv) begin
            $error("phase_advanced: expected %b, got %b", head_pins.adv, out_tuser);
            mismatches++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        next_pins = predict_pins(in_tuser, in_tdata[4:0], in_tdata[12:5]);
        // Hand-written rows override the prediction; the model state still advances.
        pending_pins.push_back(pin_en ? pin_val : next_pins);
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready)
        tick_len[cfg_paddr[3:2]] = cfg_pwdata[cbld_pkg::TICK_W-1:0];
    end
  end

  // Watchdog: drop out with a failure if the run hangs.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Result side back-pressure: mostly short stalls, a few long ones, and calm
  // stretches with tready held high.
  // --------------------------------------------------------------------------
  int   rx_stall = 0;
  int   rx_calm = 0;
  int   rx_roll;
  logic rx_ready;

  always @(posedge clk) begin
    rx_roll = $urandom_range(0, 99);
    if (rx_calm > 0) begin
      rx_calm--;
      rx_ready = 1'b1;
    end else if (rx_stall > 0) begin
      rx_stall--;
      rx_ready = 1'b0;
    end else if (rx_roll < 2) begin
      rx_calm  = $urandom_range(50, 200);
      rx_ready = 1'b1;
    end else if (rx_roll < 60) begin
      rx_ready = 1'b1;
    end else if (rx_roll < 92) begin
      rx_stall = $urandom_range(0, 3);
      rx_ready = 1'b0;
    end else begin
      rx_stall = $urandom_range(5, 40);
      rx_ready = 1'b0;
    end
    out_tready <= rx_ready;
  end

  // --------------------------------------------------------------------------
  // Sender side.
  // --------------------------------------------------------------------------
  int tx_calm = 0;

  // Idle gap after a transfer: usually none or short, now and then long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (tx_calm > 0) begin
      tx_calm--;
      return 0;
    end
    if (roll < 2) begin
      tx_calm = $urandom_range(30, 120);
      return 0;
    end
    if (roll < 50) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // Present one item and hold it until the transfer. On a zero gap, valid stays
  // high so the next item follows without a bubble.
  task automatic send_item(input logic is_set, input logic [cbld_pkg::POS_W-1:0] pos,
                           input logic [cbld_pkg::BRT_W-1:0] brt, input logic pin,
                           input pins_t pv);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= is_set;
    in_tdata  <= {3'b000, brt, pos};
    pin_en    <= pin;
    pin_val   <= pv;
    do @(posedge clk); while (!in_tready);
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and hold off until every pending result has been seen. The first
  // edge lets the monitor record an item that transferred at the last edge.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_pins.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Setup cycle, then access cycle until pready; then drop psel again.
  task automatic write_reg(input int idx, input logic [cbld_pkg::TICK_W-1:0] val);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= 4'(idx * 4);
    cfg_pwdata  <= {24'd0, val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_all(input logic [cbld_pkg::TICK_W-1:0] v0,
                           input logic [cbld_pkg::TICK_W-1:0] v1,
                           input logic [cbld_pkg::TICK_W-1:0] v2,
                           input logic [cbld_pkg::TICK_W-1:0] v3);
    write_reg(REG_TICKS_C0, v0);
    write_reg(REG_TICKS_C1, v1);
    write_reg(REG_TICKS_C2, v2);
    write_reg(REG_TICKS_C3, v3);
  endtask

  // Random phase length: mostly short so phases turn over often.
  function automatic logic [cbld_pkg::TICK_W-1:0] pick_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return cbld_pkg::TICK_W'($urandom_range(1, 6));
    if (roll < 90) return cbld_pkg::TICK_W'($urandom_range(1, 40));
    if (roll < 95) return 8'd255;
    return cbld_pkg::TICK_W'($urandom_range(1, 255));
  endfunction

  // Directed table. Pinned rows: reset pins, first two phase steps from the
  // default lengths, and set items that must leave the pins untouched.
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{FUNC_SET,  5'd20, 8'hFF, 1'b1, '{5'b00001, 5'b00000, 1'b0}}, // out of range, reset pins
    '{FUNC_TICK, 5'd0,  8'h00, 1'b1, '{5'b00010, 5'b00010, 1'b1}},
    '{FUNC_TICK, 5'd31, 8'hFF, 1'b1, '{5'b00100, 5'b00100, 1'b1}},
    '{FUNC_SET,  5'd0,  8'hFF, 1'b1, '{5'b00100, 5'b00100, 1'b0}}, // pins wait for next phase
    '{FUNC_SET,  5'd19, 8'h00, 1'b1, '{5'b00100, 5'b00100, 1'b0}},
    '{FUNC_SET,  5'd31, 8'hA5, 1'b1, '{5'b00100, 5'b00100, 1'b0}}, // out of range
    '{FUNC_SET,  5'd5,  8'h9F, 1'b0, NO_PIN},
    '{FUNC_SET,  5'd10, 8'h50, 1'b0, NO_PIN},
    '{FUNC_SET,  5'd14, 8'hF0, 1'b0, NO_PIN},
    '{FUNC_SET,  5'd7,  8'h0F, 1'b0, NO_PIN},                      // low nibble ignored
    '{FUNC_SET,  5'd12, 8'h80, 1'b0, NO_PIN},
    '{FUNC_SET,  5'd16, 8'h10, 1'b0, NO_PIN},
    '{FUNC_SET,  5'd3,  8'h01, 1'b0, NO_PIN},
    '{FUNC_TICK, 5'd0,  8'h00, 1'b0, NO_PIN},
    '{FUNC_TICK, 5'd0,  8'h00, 1'b0, NO_PIN},
    '{FUNC_TICK, 5'd0,  8'h00, 1'b0, NO_PIN},                      // wrap into cycle one
    '{FUNC_TICK, 5'd0,  8'h00, 1'b0, NO_PIN},
    '{FUNC_TICK, 5'd0,  8'h00, 1'b0, NO_PIN},
    '{FUNC_SET,  5'd9,  8'hC0, 1'b0, NO_PIN},
    '{FUNC_TICK, 5'd0,  8'h00, 1'b0, NO_PIN},
    '{FUNC_TICK, 5'd0,  8'h00, 1'b0, NO_PIN},
    '{FUNC_TICK, 5'd0,  8'h00, 1'b0, NO_PIN},
    '{FUNC_TICK, 5'd0,  8'h00, 1'b0, NO_PIN},
    '{FUNC_TICK, 5'd0,  8'h00, 1'b0, NO_PIN},
    '{FUNC_TICK, 5'd0,  8'h00, 1'b0, NO_PIN}
  };

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  logic [cbld_pkg::TICK_W-1:0] len0, len1, len2, len3;
  logic                        item_set;
  logic [cbld_pkg::POS_W-1:0]  item_pos;

  initial begin
    reset_pins_model();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table with the default phase lengths.
    foreach (directed_rows[i])
      send_item(directed_rows[i].is_set, directed_rows[i].pos, directed_rows[i].brt,
                directed_rows[i].pinned, directed_rows[i].pins);

    // Lowered phase length: build up a count under long phases, then shorten
    // them below the count so the next tick expires at once.
    drain();
    write_all(8'd255, 8'd255, 8'd255, 8'd255);
    repeat (6) send_item(FUNC_TICK, 5'd0, 8'h00, 1'b0, NO_PIN);
    drain();
    write_all(8'd3, 8'd3, 8'd3, 8'd3);
    repeat (2) send_item(FUNC_TICK, 5'd0, 8'h00, 1'b0, NO_PIN);

    // Zero phase length: every tick advances.
    drain();
    write_all(8'd0, 8'd0, 8'd0, 8'd0);
    repeat (4) send_item(FUNC_TICK, 5'd0, 8'h00, 1'b0, NO_PIN);

    // Random phases under shifting phase lengths, the extremes first.
    for (int p = 0; p < RAND_PHASES; p++) begin
      drain();
      case (p)
        0:       write_all(8'd1, 8'd1, 8'd1, 8'd1);
        1:       write_all(8'd255, 8'd255, 8'd255, 8'd255);
        5:       write_all(8'd1, 8'd2, 8'd8, 8'd16);
        default: begin
          len0 = pick_len();
          len1 = pick_len();
          len2 = pick_len();
          len3 = pick_len();
          write_all(len0, len1, len2, len3);
        end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        item_set = ($urandom_range(0, 99) < 30) ? FUNC_SET : FUNC_TICK;
        item_pos = ($urandom_range(0, 9) == 0) ?
                   cbld_pkg::POS_W'($urandom_range(cbld_pkg::LED_COUNT, 31)) :
                   cbld_pkg::POS_W'($urandom_range(0, cbld_pkg::LED_COUNT - 1));
        send_item(item_set, item_pos, cbld_pkg::BRT_W'($urandom_range(0, 255)),
                  1'b0, NO_PIN);
        // Now and then hold off until the result side has caught up.
        if ($urandom_range(0, 99) == 0) drain();
      end
    end

    // Wait out the tail, then wait DRAIN_CYCLES more to catch stray results.
    drain();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
